FILE: hw/rtl/mfts_pkg.sv
package mfts_pkg;

  localparam int KIND_W     = 3;
  localparam int ID_FIELD_W = 8;
  localparam int LVL_FIELD_W = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_ADD    = 3'd0;
  localparam kind_t KIND_EXPIRE = 3'd1;
  localparam kind_t KIND_YIELD  = 3'd2;
  localparam kind_t KIND_BLOCK  = 3'd3;
  localparam kind_t KIND_FINISH = 3'd4;

  typedef logic [ID_FIELD_W-1:0]  tid_t;
  typedef logic [LVL_FIELD_W-1:0] lvl_field_t;

endpackage

FILE: hw/rtl/mfts_req_if.sv
interface mfts_req_if import mfts_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  tid_t  thread_id;

  modport source (output valid, output kind, output thread_id, input ready);
  modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

FILE: hw/rtl/mfts_rsp_if.sv
interface mfts_rsp_if import mfts_pkg::*; ();
  logic       valid;
  logic       ready;
  tid_t       running_id;
  lvl_field_t running_level;
  logic       running_valid;
  logic       dropped;

  modport source (output valid, output running_id, output running_level,
                  output running_valid, output dropped, input ready);
  modport sink   (input valid, input running_id, input running_level,
                  input running_valid, input dropped, output ready);
endinterface

FILE: hw/rtl/mfts_ram.sv
module mfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/multilevel_feedback_thread_scheduler_unit.sv
// Multilevel feedback thread scheduler. Ready thread ids wait in LEVELS fifos
// (level 0 highest) held in one id memory of LEVELS*LEVEL_DEPTH entries; the
// running thread is the head of its level. Each accepted request gives one
// response with the running thread after it. An add appends to level 0 and
// then loads the response, flagging dropped if level 0 is full.
// A schedule request (slice expired, yield, blocked, finished) goes through
// these steps in order: the pop of the running thread, its write-back into
// the id memory (a second one when a demotion finds the next level full), the
// priority search and the registered read of the new head, then the load of
// the response register. A removal skips the write-back, the read is skipped
// when the search finds no ready thread, and a request while idle skips the
// write-back. Unused kinds go straight to the response load with no
// state change. A new request is taken on the cycle after the previous one
// has loaded its response; the response register lets it wait for the
// consumer meanwhile, and a stalled consumer holds the block in that step.
// mode resets to 1 (multilevel feedback); 0 is round robin on level 0.
module multilevel_feedback_thread_scheduler_unit import mfts_pkg::*; #(
  parameter int LEVELS      = 4,
  parameter int LEVEL_DEPTH = 64,
  parameter int ID_WIDTH    = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  mfts_req_if.sink   req,
  mfts_rsp_if.source rsp
);

  localparam int LvlW  = $clog2(LEVELS);
  localparam int PtrW  = $clog2(LEVEL_DEPTH);
  localparam int CntW  = $clog2(LEVEL_DEPTH + 1);
  localparam int SumW  = CntW + 1;
  localparam int Ents  = LEVELS * LEVEL_DEPTH;
  localparam int AddrW = $clog2(Ents);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PUSH,
    S_FIND,
    S_READ,
    S_DONE
  } state_t;

  state_t state;

  logic                mode;
  logic                running;
  logic [LvlW-1:0]     cur_lvl;
  logic [ID_WIDTH-1:0] cur_id;
  logic [PtrW-1:0]     head [LEVELS];
  logic [CntW-1:0]     cnt  [LEVELS];
  logic [LvlW-1:0]     tgt;
  logic                is_add;
  kind_t               kind_r;
  logic [ID_WIDTH-1:0] id_r;
  logic                dropped;

  logic       out_valid;
  tid_t       out_id;
  lvl_field_t out_lvl;
  logic       out_run;
  logic       out_drop;

  logic [LvlW-1:0]     sel;
  logic [PtrW-1:0]     head_sel;
  logic [CntW-1:0]     cnt_sel;
  logic [SumW-1:0]     psum;
  logic [PtrW-1:0]     wpos;
  logic [PtrW-1:0]     head_inc;
  logic                full_sel;
  logic                found;
  logic [LvlW-1:0]     found_lvl;
  logic                demote;
  logic                remove;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [AddrW-1:0]    ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;
  logic [ID_WIDTH-1:0] id_in;

  function automatic logic [AddrW-1:0] ent_addr(input logic [LvlW-1:0] l,
                                                input logic [PtrW-1:0] p);
    return AddrW'(AddrW'(l) * AddrW'(LEVEL_DEPTH) + AddrW'(p));
  endfunction

  assign id_in = ID_WIDTH'({{ID_WIDTH{1'b0}}, req.thread_id});

  // one level index per step: running level, push target, or search result
  always_comb begin
    case (state)
      S_POP:   sel = cur_lvl;
      S_PUSH:  sel = tgt;
      default: sel = found_lvl;
    endcase
  end

  assign head_sel = head[sel];
  assign cnt_sel  = cnt[sel];
  assign full_sel = (cnt_sel == CntW'(LEVEL_DEPTH));
  assign head_inc = (head_sel == PtrW'(LEVEL_DEPTH - 1)) ? '0 : head_sel + 1'b1;

  // tail position with wrap
  assign psum = SumW'(head_sel) + SumW'(cnt_sel);
  assign wpos = (psum >= SumW'(LEVEL_DEPTH)) ? PtrW'(psum - SumW'(LEVEL_DEPTH))
                                             : PtrW'(psum);

  // first non-empty level; round robin looks at level 0 only
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt[l] != '0 && (mode || l == 0)) begin
        found     = 1'b1;
        found_lvl = LvlW'(l);
      end
    end
  end

  assign remove = (kind_r == KIND_BLOCK) || (kind_r == KIND_FINISH);
  assign demote = mode && (kind_r == KIND_EXPIRE) && (cur_lvl != LvlW'(LEVELS - 1));

  assign ram_we    = (state == S_PUSH) && !full_sel;
  assign ram_waddr = ent_addr(tgt, wpos);
  assign ram_raddr = ent_addr(found_lvl, head_sel);

  mfts_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (Ents)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (id_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.running_id    = out_id;
  assign rsp.running_level = out_lvl;
  assign rsp.running_valid = out_run;
  assign rsp.dropped       = out_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= 1'b1;
      running   <= 1'b0;
      cur_lvl   <= '0;
      cur_id    <= '0;
      out_valid <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head[l] <= '0;
        cnt[l]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      // the done step reloads the response register itself
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            dropped <= 1'b0;
            kind_r  <= req.kind;
            id_r    <= id_in;
            case (req.kind) inside
              KIND_ADD: begin
                is_add <= 1'b1;
                tgt    <= '0;
                state  <= S_PUSH;
              end
              [KIND_EXPIRE:KIND_FINISH]: begin
                is_add <= 1'b0;
                state  <= S_POP;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_POP: begin
          if (running && cnt_sel != '0) begin
            head[cur_lvl] <= head_inc;
            cnt[cur_lvl]  <= cnt_sel - 1'b1;
            if (remove) begin
              state <= S_FIND;
            end else begin
              id_r  <= cur_id;
              tgt   <= demote ? cur_lvl + 1'b1 : cur_lvl;
              state <= S_PUSH;
            end
          end else begin
            state <= S_FIND;
          end
        end

        S_PUSH: begin
          if (full_sel) begin
            if (is_add) begin
              dropped <= 1'b1;
              state   <= S_DONE;
            end else begin
              // demotion target full: rotate in own level instead
              tgt <= cur_lvl;
            end
          end else begin
            cnt[tgt] <= cnt_sel + 1'b1;
            state    <= is_add ? S_DONE : S_FIND;
          end
        end

        S_FIND: begin
          if (found) begin
            cur_lvl <= found_lvl;
            state   <= S_READ;
          end else begin
            running <= 1'b0;
            state   <= S_DONE;
          end
        end

        S_READ: begin
          cur_id  <= ram_rdata;
          running <= 1'b1;
          state   <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_run   <= running;
            out_id    <= running ? ID_FIELD_W'({{ID_FIELD_W{1'b0}}, cur_id}) : '0;
            out_lvl   <= running ? LVL_FIELD_W'({{LVL_FIELD_W{1'b0}}, cur_lvl}) : '0;
            out_drop  <= dropped;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
